@@ hdl/rmfw_pkg.sv @@
// shared constants and types of the range max-frequency window engine
`default_nettype none

package rmfw_pkg;

    // fixed payload widths
    localparam int ELEM_W  = 12;
    localparam int RANGE_W = 13;
    localparam int COUNT_W = 13;

    // default sizing
    localparam int DEF_MAX_ELEMENTS = 4096;
    localparam int DEF_VALUE_DOMAIN = 4096;

    // input word kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // strobes from the sequencer to the count tables
    typedef struct packed {
        logic vc_rd;
        logic vc_we;
        logic coc_rd;
        logic coc_we;
    } t_tbl_cmd;

    typedef struct packed {
        logic clearing;
    } t_tbl_status;

endpackage

`default_nettype wire

@@ hdl/rmfw_if.sv @@
// valid/ready channels for input and result words
`default_nettype none

interface rmfw_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [rmfw_pkg::ELEM_W-1:0]  element_value;
    logic [rmfw_pkg::RANGE_W-1:0] range_left;
    logic [rmfw_pkg::RANGE_W-1:0] range_right;

    modport source (
        output valid, mode, element_value, range_left, range_right,
        input  ready
    );
    modport sink (
        input  valid, mode, element_value, range_left, range_right,
        output ready
    );
endinterface

interface rmfw_out_if;
    logic                         valid;
    logic                         ready;
    logic [rmfw_pkg::COUNT_W-1:0] max_count;
    logic                         bad_range;

    modport source (
        output valid, max_count, bad_range,
        input  ready
    );
    modport sink (
        input  valid, max_count, bad_range,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/range_max_frequency_window.sv @@
// top level of the range max-frequency window engine: sequencer and window state
//
// A load word (mode 0) appends element_value, reduced modulo VALUE_DOMAIN, to the
// element store and yields no result; loads past MAX_ELEMENTS are dropped. Loads
// may follow each other back to back. A query word (mode 1) returns one result
// word: the highest number of times any single value occurs among elements
// range_left..range_right (1-based, inclusive). A query with range_left of zero,
// range_left above range_right or range_right beyond the loaded length returns
// bad_range = 1 with max_count = 0 and leaves the window untouched. A valid query
// moves the current window one element at a time, first widening both ends and
// then narrowing them; every element added or removed is a read-modify-write on
// the per-value count memory and the count-of-counts memory (store read, count
// read, count-of-counts read on both ports, two writes through the single write
// port). The work of a query therefore grows with the elements added and
// removed, so nearby successive ranges answer quickly. The input is not accepted
// while a query is in progress; a finished result waits in an output register,
// and a query that finishes while that result is still untaken waits before its
// own result is stored. After reset a clearing pass zeroes both count memories
// before the first word is taken.
`default_nettype none

module range_max_frequency_window #(
    parameter int MAX_ELEMENTS = rmfw_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_DOMAIN = rmfw_pkg::DEF_VALUE_DOMAIN
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmfw_in_if.sink    i_in,
    rmfw_out_if.source o_out
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    localparam int VW = $clog2(VALUE_DOMAIN);
    localparam int RW = rmfw_pkg::RANGE_W;
    localparam int OW = rmfw_pkg::COUNT_W;
    // common width for range checks and output masking
    localparam int CW = (LW > RW) ? LW : RW;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_ELEMENTS);

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_CHECK  = 9'b000001000,
        ST_RD_CNT = 9'b000010000,
        ST_RD_COC = 9'b000100000,
        ST_WR_A   = 9'b001000000,
        ST_WR_B   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    // window walk phases: widen low end, widen high end, narrow low, narrow high
    typedef enum logic [3:0] {
        PH_GROW_LO   = 4'b0001,
        PH_GROW_HI   = 4'b0010,
        PH_SHRINK_LO = 4'b0100,
        PH_SHRINK_HI = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [LW-1:0] r_len,  n_len;
    logic [LW-1:0] r_ws,   n_ws;
    logic [LW-1:0] r_we,   n_we;
    logic [LW-1:0] r_ns,   n_ns;
    logic [LW-1:0] r_ne,   n_ne;
    logic [LW-1:0] r_pos,  n_pos;
    logic [LW-1:0] r_stop, n_stop;
    logic [LW-1:0] r_cur,  n_cur;
    logic [LW-1:0] r_c,    n_c;
    logic [LW-1:0] r_cn,   n_cn;
    logic [VW-1:0] r_v,    n_v;
    logic          r_add,  n_add;
    logic          r_bad,  n_bad;

    logic          r_ov,   n_ov;
    logic [OW-1:0] r_omax, n_omax;
    logic          r_obad, n_obad;

    // handshake and query decode
    logic          in_acc;
    logic          is_query;
    logic          ld_en;
    logic [CW-1:0] left_x;
    logic [CW-1:0] right_x;
    logic [CW-1:0] len_x;
    logic [CW-1:0] cur_x;
    logic          query_bad;

    // memory side
    logic                  st_rd_en;
    logic [VW-1:0]         st_rd_data;
    rmfw_pkg::t_tbl_cmd    tbl_cmd;
    rmfw_pkg::t_tbl_status tbl_status;
    logic [LW-1:0]         vc_rd_data;
    logic [LW-1:0]         coc_a;
    logic [LW-1:0]         coc_b;
    logic [LW-1:0]         coc_wr_addr;
    logic [LW-1:0]         coc_wr_data;

    // read-modify-write arithmetic
    logic [LW-1:0] cnt_nb;
    logic          cnt_skip;
    logic          dec_ok;
    logic [LW-1:0] ca_new;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_query   = (i_in.mode == rmfw_pkg::MODE_QUERY);
    assign ld_en      = in_acc && (i_in.mode == rmfw_pkg::MODE_LOAD) && (r_len != LEN_MAX);

    assign left_x    = CW'(i_in.range_left);
    assign right_x   = CW'(i_in.range_right);
    assign len_x     = CW'(r_len);
    assign cur_x     = CW'(r_cur);
    assign query_bad = (left_x == '0) || (left_x > right_x) || (right_x > len_x);

    // count step: neighbor count, saturation or empty guard
    assign cnt_nb   = r_add ? vc_rd_data + 1'b1 : vc_rd_data - 1'b1;
    assign cnt_skip = r_add ? (vc_rd_data >= LEN_MAX) : (vc_rd_data == '0);
    // old count bucket shrinks; bucket zero is not kept
    assign dec_ok   = (coc_a != '0) && (!r_add || (r_c != '0));
    assign ca_new   = coc_a - LW'(dec_ok);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_len   = r_len;
        n_ws    = r_ws;
        n_we    = r_we;
        n_ns    = r_ns;
        n_ne    = r_ne;
        n_pos   = r_pos;
        n_stop  = r_stop;
        n_cur   = r_cur;
        n_c     = r_c;
        n_cn    = r_cn;
        n_v     = r_v;
        n_add   = r_add;
        n_bad   = r_bad;
        n_ov    = r_ov;
        n_omax  = r_omax;
        n_obad  = r_obad;

        st_rd_en    = 1'b0;
        tbl_cmd     = '0;
        coc_wr_addr = r_c;
        coc_wr_data = ca_new;

        // result word leaves
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        if (ld_en) begin
            n_len = r_len + 1'b1;
        end

        unique case (r_state)
            ST_CLEAR: begin
                if (!tbl_status.clearing) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    n_bad   = query_bad;
                    n_ns    = LW'(left_x - 1'b1);
                    n_ne    = LW'(right_x);
                    n_phase = PH_GROW_LO;
                    n_state = query_bad ? ST_DONE : ST_SETUP;
                end
            end
            ST_SETUP: begin
                unique case (r_phase)
                    PH_GROW_LO: begin
                        n_pos  = r_ns;
                        n_stop = r_ws;
                        n_add  = 1'b1;
                    end
                    PH_GROW_HI: begin
                        n_pos  = r_we;
                        n_stop = r_ne;
                        n_add  = 1'b1;
                    end
                    PH_SHRINK_LO: begin
                        n_pos  = r_ws;
                        n_stop = r_ns;
                        n_add  = 1'b0;
                    end
                    PH_SHRINK_HI: begin
                        n_pos  = r_ne;
                        n_stop = r_we;
                        n_add  = 1'b0;
                    end
                    default: begin
                        n_pos  = r_pos;
                    end
                endcase
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_pos < r_stop) begin
                    st_rd_en = 1'b1;
                    n_state  = ST_RD_CNT;
                end else begin
                    unique case (r_phase)
                        PH_GROW_LO:   n_phase = PH_GROW_HI;
                        PH_GROW_HI:   n_phase = PH_SHRINK_LO;
                        PH_SHRINK_LO: n_phase = PH_SHRINK_HI;
                        PH_SHRINK_HI: n_phase = PH_GROW_LO;
                        default:      n_phase = PH_GROW_LO;
                    endcase
                    n_state = (r_phase == PH_SHRINK_HI) ? ST_DONE : ST_SETUP;
                end
            end
            ST_RD_CNT: begin
                // element value is back, fetch its count
                tbl_cmd.vc_rd = 1'b1;
                n_v           = st_rd_data;
                n_state       = ST_RD_COC;
            end
            ST_RD_COC: begin
                if (cnt_skip) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = ST_CHECK;
                end else begin
                    tbl_cmd.coc_rd = 1'b1;
                    tbl_cmd.vc_we  = 1'b1;
                    n_c            = vc_rd_data;
                    n_cn           = cnt_nb;
                    n_state        = ST_WR_A;
                end
            end
            ST_WR_A: begin
                tbl_cmd.coc_we = dec_ok;
                coc_wr_addr    = r_c;
                coc_wr_data    = ca_new;
                if (r_add) begin
                    if (r_cn > r_cur) begin
                        n_cur = r_cn;
                    end
                end else if ((r_c == r_cur) && (ca_new == '0) && (r_cur != '0)) begin
                    // last value at the top count just dropped
                    n_cur = r_cur - 1'b1;
                end
                n_state = ST_WR_B;
            end
            ST_WR_B: begin
                tbl_cmd.coc_we = r_add || (r_cn != '0);
                coc_wr_addr    = r_cn;
                coc_wr_data    = coc_b + 1'b1;
                n_pos          = r_pos + 1'b1;
                n_state        = ST_CHECK;
            end
            ST_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_obad  = r_bad;
                    n_omax  = r_bad ? '0 : cur_x[OW-1:0];
                    if (!r_bad) begin
                        n_ws = r_ns;
                        n_we = r_ne;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_GROW_LO;
            r_len   <= '0;
            r_ws    <= '0;
            r_we    <= '0;
            r_cur   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_ws    <= n_ws;
            r_we    <= n_we;
            r_cur   <= n_cur;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ns   <= n_ns;
        r_ne   <= n_ne;
        r_pos  <= n_pos;
        r_stop <= n_stop;
        r_c    <= n_c;
        r_cn   <= n_cn;
        r_v    <= n_v;
        r_add  <= n_add;
        r_bad  <= n_bad;
        r_omax <= n_omax;
        r_obad <= n_obad;
    end

    assign o_out.valid     = r_ov;
    assign o_out.max_count = r_omax;
    assign o_out.bad_range = r_obad;

    rmfw_elem_store #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_DOMAIN (VALUE_DOMAIN)
    ) u_store (
        .i_clk      (i_clk),
        .i_ld_en    (ld_en),
        .i_ld_addr  (r_len[AW-1:0]),
        .i_ld_value (i_in.element_value),
        .i_rd_en    (st_rd_en),
        .i_rd_addr  (r_pos[AW-1:0]),
        .o_rd_data  (st_rd_data)
    );

    rmfw_count_tables #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_DOMAIN (VALUE_DOMAIN)
    ) u_tables (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (tbl_cmd),
        .i_vc_rd_addr    (st_rd_data),
        .i_vc_wr_addr    (r_v),
        .i_vc_wr_data    (cnt_nb),
        .o_vc_rd_data    (vc_rd_data),
        .i_coc_rd_addr_a (vc_rd_data),
        .i_coc_rd_addr_b (cnt_nb),
        .i_coc_wr_addr   (coc_wr_addr),
        .i_coc_wr_data   (coc_wr_data),
        .o_coc_rd_data_a (coc_a),
        .o_coc_rd_data_b (coc_b),
        .o_status        (tbl_status)
    );

`ifndef SYNTH
    // no word taken while the count memories are being cleared
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_status.clearing |-> !i_in.ready)
        else $error("input ready during table clearing");

    // running maximum never exceeds the window size between queries
    a_max_within_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cur <= (r_we - r_ws)))
        else $error("current max exceeds window length");

    // count-of-counts bucket zero is never touched by a step
    a_no_bucket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_cmd.coc_we && !tbl_status.clearing) |-> (coc_wr_addr != '0))
        else $error("write to count-of-counts entry zero");

    // a finished query always lands in the output register
    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_ov || o_out.ready)) |=> o_out.valid)
        else $error("finished query produced no result word");
`endif

endmodule

`default_nettype wire

@@ hdl/rmfw_elem_store.sv @@
// element store memory with value-domain reduction on the load path
`default_nettype none

module rmfw_elem_store #(
    parameter int MAX_ELEMENTS = rmfw_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_DOMAIN = rmfw_pkg::DEF_VALUE_DOMAIN
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_ld_en,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]   i_ld_addr,
    input  wire logic [rmfw_pkg::ELEM_W-1:0]       i_ld_value,
    input  wire logic                              i_rd_en,
    input  wire logic [$clog2(MAX_ELEMENTS)-1:0]   i_rd_addr,
    output logic      [$clog2(VALUE_DOMAIN)-1:0]   o_rd_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int VW = $clog2(VALUE_DOMAIN);
    localparam int EW = rmfw_pkg::ELEM_W;
    // reciprocal for an exact quotient of an EW-bit value
    localparam int RS = EW + VW;
    localparam logic [63:0] RECIP =
        ((64'd1 << RS) + 64'(VALUE_DOMAIN) - 64'd1) / 64'(VALUE_DOMAIN);
    localparam int MW = EW + 2;
    localparam logic [MW-1:0] RECIP_N = RECIP[MW-1:0];
    localparam int PW = EW + MW;

    logic [VW-1:0] r_mem [MAX_ELEMENTS];
    logic [VW-1:0] r_rd_q;

    logic          r_ld_pend;
    logic [AW-1:0] r_ld_addr;
    logic [EW-1:0] r_ld_val;
    logic [EW-1:0] r_ld_q;

    logic [PW-1:0] prod;
    logic [31:0]   qd;
    logic [31:0]   rem;
    logic [31:0]   rem_c;

    // stage 1: quotient estimate
    assign prod = PW'(i_ld_value) * PW'(RECIP_N);

    // stage 2: remainder with one correction step
    assign qd    = 32'(r_ld_q) * 32'(VALUE_DOMAIN);
    assign rem   = 32'(r_ld_val) - qd;
    assign rem_c = (rem >= 32'(VALUE_DOMAIN)) ? rem - 32'(VALUE_DOMAIN) : rem;

    always_ff @(posedge i_clk) begin
        r_ld_pend <= i_ld_en;
        r_ld_addr <= i_ld_addr;
        r_ld_val  <= i_ld_value;
        r_ld_q    <= EW'(prod >> RS);
    end

    always_ff @(posedge i_clk) begin
        if (r_ld_pend) begin
            r_mem[r_ld_addr] <= VW'(rem_c);
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_q;

endmodule

`default_nettype wire

@@ hdl/rmfw_count_tables.sv @@
// per-value count and count-of-counts memories with post-reset clearing sweep
`default_nettype none

module rmfw_count_tables #(
    parameter int MAX_ELEMENTS = rmfw_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_DOMAIN = rmfw_pkg::DEF_VALUE_DOMAIN
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rmfw_pkg::t_tbl_cmd                  i_cmd,
    input  wire logic [$clog2(VALUE_DOMAIN)-1:0]     i_vc_rd_addr,
    input  wire logic [$clog2(VALUE_DOMAIN)-1:0]     i_vc_wr_addr,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   i_vc_wr_data,
    output logic      [$clog2(MAX_ELEMENTS+1)-1:0]   o_vc_rd_data,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   i_coc_rd_addr_a,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   i_coc_rd_addr_b,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   i_coc_wr_addr,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   i_coc_wr_data,
    output logic      [$clog2(MAX_ELEMENTS+1)-1:0]   o_coc_rd_data_a,
    output logic      [$clog2(MAX_ELEMENTS+1)-1:0]   o_coc_rd_data_b,
    output rmfw_pkg::t_tbl_status                    o_status
);

    localparam int VW    = $clog2(VALUE_DOMAIN);
    localparam int LW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CLR_N = (VALUE_DOMAIN > MAX_ELEMENTS + 1) ? VALUE_DOMAIN
                                                             : MAX_ELEMENTS + 1;
    localparam int CLRW  = $clog2(CLR_N);
    localparam logic [CLRW-1:0] CLR_LAST = CLRW'(CLR_N - 1);
    localparam logic [CLRW:0]   VD_C     = (CLRW + 1)'(VALUE_DOMAIN);
    localparam logic [CLRW:0]   CC_LAST  = (CLRW + 1)'(MAX_ELEMENTS);

    logic [LW-1:0] r_vc  [VALUE_DOMAIN];
    logic [LW-1:0] r_coc [MAX_ELEMENTS + 1];
    logic [LW-1:0] r_vc_q;
    logic [LW-1:0] r_coc_qa;
    logic [LW-1:0] r_coc_qb;

    logic            r_clr_busy;
    logic [CLRW-1:0] r_clr;

    logic          vc_we;
    logic [VW-1:0] vc_wa;
    logic [LW-1:0] vc_wd;
    logic          coc_we;
    logic [LW-1:0] coc_wa;
    logic [LW-1:0] coc_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
        end else if (r_clr_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sweep owns the write ports while clearing
    always_comb begin
        if (r_clr_busy) begin
            vc_we  = ({1'b0, r_clr} < VD_C);
            vc_wa  = r_clr[VW-1:0];
            vc_wd  = '0;
            coc_we = ({1'b0, r_clr} <= CC_LAST);
            coc_wa = r_clr[LW-1:0];
            coc_wd = '0;
        end else begin
            vc_we  = i_cmd.vc_we;
            vc_wa  = i_vc_wr_addr;
            vc_wd  = i_vc_wr_data;
            coc_we = i_cmd.coc_we;
            coc_wa = i_coc_wr_addr;
            coc_wd = i_coc_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vc_we) begin
            r_vc[vc_wa] <= vc_wd;
        end
        if (i_cmd.vc_rd) begin
            r_vc_q <= r_vc[i_vc_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (coc_we) begin
            r_coc[coc_wa] <= coc_wd;
        end
        if (i_cmd.coc_rd) begin
            r_coc_qa <= r_coc[i_coc_rd_addr_a];
            r_coc_qb <= r_coc[i_coc_rd_addr_b];
        end
    end

    assign o_vc_rd_data    = r_vc_q;
    assign o_coc_rd_data_a = r_coc_qa;
    assign o_coc_rd_data_b = r_coc_qb;
    assign o_status.clearing = r_clr_busy;

endmodule

`default_nettype wire

@@ tb/sv/range_max_frequency_window_test.sv @@
// self-checking testbench for the range max-frequency window engine
`timescale 1ns / 100ps

typedef logic [rmfw_pkg::COUNT_W-1:0] t_freq_count;
typedef logic [rmfw_pkg::ELEM_W-1:0]  t_elem;
typedef logic [rmfw_pkg::RANGE_W-1:0] t_range;

typedef struct packed {
    t_freq_count max_count;
    logic        bad_range;
} t_freq_answer;

// tracks the loaded array and the sliding window, predicts each query answer
class window_frequency_tracker;
    t_elem elements [rmfw_pkg::DEF_MAX_ELEMENTS];
    t_freq_count value_count [rmfw_pkg::DEF_VALUE_DOMAIN];
    t_freq_count count_freq [rmfw_pkg::DEF_MAX_ELEMENTS + 1];
    int unsigned stored_len;
    int unsigned win_lo;
    int unsigned win_hi;
    t_freq_count top_count;
    t_freq_answer pending_answers [$];
    int unsigned errors;

    function new();
        stored_len = 0;
        win_lo = 0;
        win_hi = 0;
        top_count = '0;
        errors = 0;
        foreach (elements[i]) elements[i] = '0;
        foreach (value_count[i]) value_count[i] = '0;
        foreach (count_freq[i]) count_freq[i] = '0;
    endfunction

    function void add_element(int unsigned pos);
        int unsigned v;
        t_freq_count c;
        v = elements[pos] % rmfw_pkg::DEF_VALUE_DOMAIN;
        c = value_count[v];
        if (c >= rmfw_pkg::DEF_MAX_ELEMENTS) return;
        if (c != 0 && count_freq[c] != 0) count_freq[c]--;
        c++;
        value_count[v] = c;
        count_freq[c]++;
        if (c > top_count) top_count = c;
    endfunction

    function void drop_element(int unsigned pos);
        int unsigned v;
        t_freq_count c;
        v = elements[pos] % rmfw_pkg::DEF_VALUE_DOMAIN;
        c = value_count[v];
        if (c == 0) return;
        if (count_freq[c] != 0) count_freq[c]--;
        // last value holding the top count just lost one
        if (c == top_count && count_freq[c] == 0 && top_count != 0) top_count--;
        c--;
        value_count[v] = c;
        if (c != 0) count_freq[c]++;
    endfunction

    function void note_word(logic mode, t_elem value, t_range left, t_range right);
        int unsigned lo_new;
        int unsigned hi_new;
        int unsigned i;
        t_freq_answer ans;
        if (mode == rmfw_pkg::MODE_LOAD) begin
            if (stored_len < rmfw_pkg::DEF_MAX_ELEMENTS) begin
                elements[stored_len] = t_elem'(value % rmfw_pkg::DEF_VALUE_DOMAIN);
                stored_len++;
            end
            return;
        end
        if (left == 0 || left > right || right > stored_len) begin
            ans.max_count = '0;
            ans.bad_range = 1'b1;
        end else begin
            lo_new = left - 1;
            hi_new = right;
            // widen both ends, then narrow
            for (i = lo_new; i < win_lo; i++) add_element(i);
            for (i = win_hi; i < hi_new; i++) add_element(i);
            for (i = win_lo; i < lo_new; i++) drop_element(i);
            for (i = hi_new; i < win_hi; i++) drop_element(i);
            win_lo = lo_new;
            win_hi = hi_new;
            ans.max_count = top_count;
            ans.bad_range = 1'b0;
        end
        pending_answers.push_back(ans);
    endfunction

    function void check_answer(t_freq_count max_count, logic bad_range);
        t_freq_answer want;
        if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: result word with no query waiting, max_count %0d bad_range %0b",
                     $time, max_count, bad_range);
            return;
        end
        want = pending_answers.pop_front();
        if (max_count !== want.max_count) begin
            errors++;
            $display("%0t: max_count expected %0d actual %0d", $time, want.max_count, max_count);
        end
        if (bad_range !== want.bad_range) begin
            errors++;
            $display("%0t: bad_range expected %0b actual %0b", $time, want.bad_range, bad_range);
        end
    endfunction
endclass

module range_max_frequency_window_test;

    localparam int FULL_LEN     = rmfw_pkg::DEF_MAX_ELEMENTS;
    // array stays short in the random phase so far window jumps stay cheap
    localparam int GROW_CAP     = 256;
    localparam int RANDOM_WORDS = 930;

    logic clk;
    logic rst_n;

    rmfw_in_if  word_in ();
    rmfw_out_if word_out ();

    window_frequency_tracker tracker;
    int unsigned burst_left;

    range_max_frequency_window i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (word_in.sink),
        .o_out   (word_out.source)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender bursts: random burst length, random gap before each burst
    task automatic send_word(logic mode, t_elem value, t_range left, t_range right);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
            if (gap != 0) begin
                word_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        word_in.valid         <= 1'b1;
        word_in.mode          <= mode;
        word_in.element_value <= value;
        word_in.range_left    <= left;
        word_in.range_right   <= right;
        do @(posedge clk); while (word_in.ready !== 1'b1);
        tracker.note_word(mode, value, left, right);
    endtask

    // unused range fields carry noise on loads
    task automatic send_load(t_elem value);
        send_word(rmfw_pkg::MODE_LOAD, value, t_range'($urandom_range(0, 8191)),
                  t_range'($urandom_range(0, 8191)));
    endtask

    task automatic send_query(int unsigned lo, int unsigned hi);
        send_word(rmfw_pkg::MODE_QUERY, t_elem'($urandom_range(0, 4095)), t_range'(lo),
                  t_range'(hi));
    endtask

    // hold the input idle until every outstanding query has answered
    task automatic wait_for_answers();
        word_in.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tracker.pending_answers.size() != 0);
    endtask

    function automatic t_elem pick_value();
        case ($urandom_range(0, 3))
            0, 1:    return t_elem'($urandom_range(0, 7));
            2:       return t_elem'(4095 - $urandom_range(0, 2));
            default: return t_elem'($urandom_range(0, 4095));
        endcase
    endfunction

    // well-formed query: mostly a small shift of the current window, sometimes a jump
    task automatic send_span_query(bit far);
        int lo;
        int hi;
        int len;
        len = int'(tracker.stored_len);
        if (far || tracker.win_hi == 0) begin
            lo = int'($urandom_range(1, len));
            hi = ($urandom_range(0, 3) == 0) ? len : ((lo + 15 < len) ? lo + 15 : len);
            hi = int'($urandom_range(lo, hi));
        end else begin
            lo = int'(tracker.win_lo) + 1 + int'($urandom_range(0, 8)) - 4;
            hi = int'(tracker.win_hi) + int'($urandom_range(0, 8)) - 4;
            if (lo < 1) lo = 1;
            if (lo > len) lo = len;
            if (hi < lo) hi = lo;
            if (hi > len) hi = len;
        end
        send_query(lo, hi);
    endtask

    // malformed query: zero left, reversed range, right past the array, or noise
    task automatic send_bad_query();
        int unsigned lo;
        int unsigned hi;
        case ($urandom_range(0, 3))
            0: begin
                lo = 0;
                hi = $urandom_range(0, 8191);
            end
            1: begin
                lo = $urandom_range(2, 8191);
                hi = $urandom_range(1, lo - 1);
            end
            2: begin
                hi = $urandom_range(tracker.stored_len + 1, 8191);
                lo = $urandom_range(1, hi);
            end
            default: begin
                lo = $urandom_range(0, 8191);
                hi = $urandom_range(0, 8191);
            end
        endcase
        send_query(lo, hi);
    endtask

    // receiver stall pattern: always ready, coin flip, periodic, or mostly stalled
    initial begin : result_stall
        int unsigned style;
        int unsigned span;
        word_out.ready <= 1'b0;
        @(posedge clk);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 160);
            for (int unsigned k = 0; k < span; k++) begin
                case (style)
                    0:       word_out.ready <= 1'b1;
                    1:       word_out.ready <= 1'($urandom_range(0, 1));
                    2:       word_out.ready <= (k % 5 != 4);
                    default: word_out.ready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // every result word taken is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && word_out.valid && word_out.ready) begin
            tracker.check_answer(word_out.max_count, word_out.bad_range);
        end
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned n;
        tracker    = new();
        burst_left = 0;
        rst_n                 <= 1'b0;
        word_in.valid         <= 1'b0;
        word_in.mode          <= rmfw_pkg::MODE_LOAD;
        word_in.element_value <= '0;
        word_in.range_left    <= '0;
        word_in.range_right   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // query on an empty array, zero left
        send_query(1, 1);
        send_query(0, 5);
        // small array with repeats, value extremes and alternating bit patterns
        send_load(12'h000);
        send_load(12'hFFF);
        send_load(12'd7);
        send_load(12'd7);
        send_load(12'hFFF);
        send_load(12'd7);
        send_load(12'h800);
        send_load(12'h555);
        send_load(12'hAAA);
        send_load(12'd7);
        send_query(1, 10);
        // narrow both ends to a single word
        send_query(2, 2);
        // reversed range, right past the loaded length
        send_query(5, 3);
        send_query(1, 11);
        // window jumps to a disjoint range
        send_query(9, 10);
        send_query(2, 5);
        // load between queries, then extend the window over it
        send_load(12'hFFF);
        send_query(2, 11);
        send_query(8191, 8191);
        send_query(4096, 4096);
        send_query(8191, 1);
        send_query(3, 3);

        for (n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && tracker.stored_len < GROW_CAP) begin
                send_load(pick_value());
            end else if (pick < 35) begin
                send_bad_query();
            end else begin
                send_span_query($urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 149) == 0) wait_for_answers();
        end

        // fill the store to capacity, then loads past the end are dropped
        wait_for_answers();
        while (tracker.stored_len < FULL_LEN) begin
            send_load(t_elem'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 3)));
        end
        send_load(12'hFFF);
        send_load(12'h000);
        send_load(12'hFFF);

        // full-length windows and the last element
        send_query(1, FULL_LEN);
        send_query(FULL_LEN, FULL_LEN);
        send_query(FULL_LEN - 1, FULL_LEN);
        send_query(1, FULL_LEN);
        send_query(FULL_LEN / 2, FULL_LEN);
        send_query(FULL_LEN, FULL_LEN - 1);
        send_query(1, FULL_LEN + 1);
        send_query(0, FULL_LEN);
        send_query(8191, 8191);
        repeat (24) send_span_query(1'b0);

        wait_for_answers();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
            $display("range_max_frequency_window_test passed");
        end else begin
            $display("range_max_frequency_window_test failed");
        end
        $finish;
    end

    // generous bound over the slowest legal run, including the clearing pass
    initial begin : watchdog
        #60_000_000;
        $display("range_max_frequency_window_test failed");
        $finish;
    end

endmodule
